// ===== src/ucfd_pkg.sv =====
package ucfd_pkg;

  localparam int BYTE_W = 8;
  localparam int CODE_W = 4;
  localparam int LEN_W  = 6;
  localparam int DEC_W  = 7;
  localparam int ID_W   = 32;

  localparam logic [BYTE_W-1:0] CH_START = 8'h23;  // '#'
  localparam logic [BYTE_W-1:0] CH_END   = 8'h21;  // '!'
  localparam logic [BYTE_W-1:0] CH_QUERY = 8'h3F;  // '?'
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;  // '9'

  localparam logic [LEN_W-1:0] QUERY_LEN = 6'd8;

  localparam int NUM_IDS = 14;
  localparam logic [CODE_W-1:0] CODE_UNKNOWN = 4'd14;

  // Command IDs, four ASCII chars packed big-endian, in code order
  localparam logic [ID_W-1:0] ID_TABLE [NUM_IDS] = '{
    32'h54696d65,  // Time
    32'h4d6f6465,  // Mode
    32'h4d436f64,  // MCod
    32'h53436f64,  // SCod
    32'h5353706b,  // SSpk
    32'h53706c74,  // Splt
    32'h52656378,  // Recx
    32'h53746f70,  // Stop
    32'h506c6179,  // Play
    32'h44656c41,  // DelA
    32'h53746174,  // Stat
    32'h4361703f,  // Cap?
    32'h4c697374,  // List
    32'h44656c65   // Dele
  };

  // Frame state as seen by the current character
  typedef struct packed {
    logic [ID_W-1:0]   window;   // last four chars before this one
    logic [BYTE_W-1:0] first;
    logic [BYTE_W-1:0] second;
    logic [BYTE_W-1:0] third;
    logic [LEN_W-1:0]  length;
  } ucfd_snap_t;

  typedef struct packed {
    logic [CODE_W-1:0] command_code;
    logic [LEN_W-1:0]  frame_length;
    logic [BYTE_W-1:0] payload_first;
    logic [BYTE_W-1:0] payload_second;
    logic [BYTE_W-1:0] payload_third;
    logic              is_query;
    logic [DEC_W-1:0]  decimal_value;
    logic              digits_valid;
  } ucfd_result_t;

  function automatic logic is_digit(input logic [BYTE_W-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

// ===== src/ucfd_frame_track.sv =====
module ucfd_frame_track import ucfd_pkg::*; #(
  parameter int FRAME_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic [BYTE_W-1:0] rx_byte,
  output ucfd_snap_t        snap
);

  localparam int PosW    = $clog2(FRAME_DEPTH);
  localparam int LenExtW = (PosW > LEN_W) ? PosW : LEN_W;

  logic [PosW-1:0]    frame_position;
  logic [PosW-1:0]    pos_eff;
  logic [PosW-1:0]    frame_position_next;
  logic [LenExtW-1:0] pos_ext;
  logic [ID_W-1:0]    id_window;
  logic [BYTE_W-1:0]  held_first, held_second, held_third;
  logic [BYTE_W-1:0]  held_first_next, held_second_next, held_third_next;

  always_comb begin
    pos_eff = (rx_byte == CH_START) ? '0 : frame_position;
    frame_position_next = (pos_eff == PosW'(FRAME_DEPTH - 1)) ? '0 : pos_eff + 1'b1;

    held_first_next  = (pos_eff == PosW'(1)) ? rx_byte : held_first;
    held_second_next = (pos_eff == PosW'(2)) ? rx_byte : held_second;
    held_third_next  = (pos_eff == PosW'(3)) ? rx_byte : held_third;

    pos_ext = LenExtW'(frame_position_next);

    snap.window = id_window;
    snap.first  = held_first_next;
    snap.second = held_second_next;
    snap.third  = held_third_next;
    snap.length = pos_ext[LEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_position <= '0;
      id_window      <= '0;
      held_first     <= '0;
      held_second    <= '0;
      held_third     <= '0;
    end else if (load) begin
      frame_position <= frame_position_next;
      id_window      <= {id_window[ID_W-BYTE_W-1:0], rx_byte};
      held_first     <= held_first_next;
      held_second    <= held_second_next;
      held_third     <= held_third_next;
    end
  end

endmodule

// ===== src/ucfd_cmd_match.sv =====
module ucfd_cmd_match import ucfd_pkg::*; (
  input  logic [ID_W-1:0]   window,
  output logic [CODE_W-1:0] command_code
);

  // Descending scan so the lowest matching index wins
  always_comb begin
    command_code = CODE_UNKNOWN;
    for (int i = NUM_IDS - 1; i >= 0; i--) begin
      if (window == ID_TABLE[i]) begin
        command_code = CODE_W'(i);
      end
    end
  end

endmodule

// ===== src/ucfd_out_buffer.sv =====
module ucfd_out_buffer import ucfd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  ucfd_result_t push_data,
  output logic         has_room,
  output logic         out_valid,
  input  logic         out_ready,
  output ucfd_result_t out_data
);

  logic         skid_valid;
  ucfd_result_t skid_data;
  logic         out_free;

  assign out_free = !out_valid || out_ready;
  assign has_room = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= push;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_data <= skid_data;
        if (push) begin
          skid_data <= push_data;
        end
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

// ===== src/uart_command_frame_decoder_unit.sv =====
// UART command frame decoder.
// Input channel (in_valid/in_ready/rx_byte) takes one received character per
// transfer. '#' restarts the frame at position 0; the position advances on
// every character and wraps at FRAME_DEPTH. Characters at positions 1..3 and
// the last four characters are held.
// A '!' produces one result transfer on the output channel (out_valid/
// out_ready): matched command code (14 = unknown), frame length, payload
// bytes 1..3, query flag, and a two-digit decimal value with its valid flag.
// Other characters produce no result.
// The result is registered, in the result register or, while the output
// stalls, the skid register. Throughput: one character per cycle while
// in_ready is high, set by one combinational pass from frame state to result.
// Stall: a two-entry output buffer (result register plus skid register) lets
// input continue while one result waits; in_ready drops only when both
// entries are full.
// Reset (rst, synchronous): clears the position, the held bytes, the
// character window and both output entries. No clearing pass is needed.
module uart_command_frame_decoder_unit import ucfd_pkg::*; #(
  parameter int FRAME_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] rx_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CODE_W-1:0] command_code,
  output logic [LEN_W-1:0]  frame_length,
  output logic [BYTE_W-1:0] payload_first,
  output logic [BYTE_W-1:0] payload_second,
  output logic [BYTE_W-1:0] payload_third,
  output logic              is_query,
  output logic [DEC_W-1:0]  decimal_value,
  output logic              digits_valid
);

  logic         in_fire;
  logic         res_push;
  ucfd_snap_t   snap;
  logic [CODE_W-1:0] code;
  ucfd_result_t res;
  ucfd_result_t out_data;
  logic         both_digits;
  logic [DEC_W-1:0] tens;
  logic [DEC_W-1:0] units;

  assign in_fire  = in_valid && in_ready;
  // A result is only produced on the terminator
  assign res_push = in_fire && (rx_byte == CH_END);

  ucfd_frame_track #(
    .FRAME_DEPTH(FRAME_DEPTH)
  ) u_track (
    .clk     (clk),
    .rst     (rst),
    .load    (in_fire),
    .rx_byte (rx_byte),
    .snap    (snap)
  );

  // Window is the four characters before the '!' itself
  ucfd_cmd_match u_match (
    .window       (snap.window),
    .command_code (code)
  );

  always_comb begin
    both_digits = is_digit(snap.first) && is_digit(snap.second);
    tens  = DEC_W'(snap.first[3:0]);
    units = DEC_W'(snap.second[3:0]);

    res.command_code   = code;
    res.frame_length   = snap.length;
    res.payload_first  = snap.first;
    res.payload_second = snap.second;
    res.payload_third  = snap.third;
    res.is_query       = (snap.first == CH_QUERY) && (snap.length == QUERY_LEN);
    // tens * 10 as shift-add; digit low nibble is the digit value
    res.decimal_value  = both_digits ? ((tens << 3) + (tens << 1) + units) : '0;
    res.digits_valid   = both_digits;
  end

  ucfd_out_buffer u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res),
    .has_room  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign command_code   = out_data.command_code;
  assign frame_length   = out_data.frame_length;
  assign payload_first  = out_data.payload_first;
  assign payload_second = out_data.payload_second;
  assign payload_third  = out_data.payload_third;
  assign is_query       = out_data.is_query;
  assign decimal_value  = out_data.decimal_value;
  assign digits_valid   = out_data.digits_valid;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

// Frame decoder bench. A tracker follows the character stream as it is
// accepted and queues one expected frame result per '!'. The monitor pops
// and compares every output transfer field by field.
module tb;
  import ucfd_pkg::*;

  localparam int DEPTH        = 64;
  localparam int MAX_WAIT     = 11;      // per-transfer idle draw, both sides
  localparam int LONG_HOLD    = 200;     // receiver hold-off for backpressure
  localparam int SETTLE       = 4;       // registered result plus skid entry
  localparam int RANDOM_CHARS = 1050;    // directed tests add roughly 550 more
  localparam int CYCLE_LIMIT  = 400000;
  localparam int NUM_CMDS     = 14;

  // Command words in code order, packed big-endian like the block sees them
  localparam logic [ID_W-1:0] CMD_WORDS [NUM_CMDS] = '{
    "Time", "Mode", "MCod", "SCod", "SSpk", "Splt", "Recx",
    "Stop", "Play", "DelA", "Stat", "Cap?", "List", "Dele"
  };

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [BYTE_W-1:0] rx_byte = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [CODE_W-1:0] command_code;
  logic [LEN_W-1:0]  frame_length;
  logic [BYTE_W-1:0] payload_first;
  logic [BYTE_W-1:0] payload_second;
  logic [BYTE_W-1:0] payload_third;
  logic              is_query;
  logic [DEC_W-1:0]  decimal_value;
  logic              digits_valid;

  // Tracked frame state, mirrors the block after every accepted character
  int unsigned       trk_pos    = 0;
  logic [ID_W-1:0]   trk_window = '0;
  logic [BYTE_W-1:0] trk_first  = '0;
  logic [BYTE_W-1:0] trk_second = '0;
  logic [BYTE_W-1:0] trk_third  = '0;
  ucfd_result_t      pending_frames [$];

  // Traffic shaping knobs
  bit source_gaps = 1'b1;                // sender idles between characters
  bit sink_stalls = 1'b1;                // receiver idles between results
  int hold_asked  = 0;                   // bumped by a test to request a hold
  int hold_given  = 0;
  int hold_left   = 0;
  int stall_left  = 0;

  int cycle_count    = 0;
  int input_stalls   = 0;                // cycles with in_valid high but in_ready low
  int chars_sent     = 0;
  int frames_checked = 0;
  int fail_count     = 0;

  uart_command_frame_decoder_unit #(.FRAME_DEPTH(DEPTH)) uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .command_code   (command_code),
    .frame_length   (frame_length),
    .payload_first  (payload_first),
    .payload_second (payload_second),
    .payload_third  (payload_third),
    .is_query       (is_query),
    .decimal_value  (decimal_value),
    .digits_valid   (digits_valid)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog; also counts cycles where the full output stalls the input
  always @(posedge clk) begin
    cycle_count++;
    if (!rst && in_valid && !in_ready) input_stalls++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL uart_command_frame_decoder_unit");
      $finish;
    end
  end

  // Advance the tracker by one accepted character; queue a result on '!'.
  // The window is compared before the '!' itself shifts in.
  function automatic void decode_char(input logic [BYTE_W-1:0] c);
    ucfd_result_t r;
    logic         first_digit;
    logic         second_digit;
    if (c == CH_START) trk_pos = 0;
    case (trk_pos)
      1: trk_first = c;
      2: trk_second = c;
      3: trk_third = c;
      default: ;
    endcase
    trk_pos = (trk_pos + 1) % DEPTH;
    if (c == CH_END) begin
      r.command_code = CODE_UNKNOWN;
      for (int k = NUM_CMDS - 1; k >= 0; k--)
        if (trk_window == CMD_WORDS[k]) r.command_code = CODE_W'(k);
      r.frame_length   = LEN_W'(trk_pos);
      r.payload_first  = trk_first;
      r.payload_second = trk_second;
      r.payload_third  = trk_third;
      r.is_query       = (trk_first == CH_QUERY) && (r.frame_length == QUERY_LEN);
      first_digit      = (trk_first >= CH_ZERO) && (trk_first <= CH_NINE);
      second_digit     = (trk_second >= CH_ZERO) && (trk_second <= CH_NINE);
      r.digits_valid   = first_digit && second_digit;
      r.decimal_value  = r.digits_valid ?
          DEC_W'((int'(trk_first) - int'(CH_ZERO)) * 10 + int'(trk_second) - int'(CH_ZERO)) :
          '0;
      pending_frames.push_back(r);
    end
    trk_window = {trk_window[ID_W-9:0], c};
  endfunction

  // One input transfer. Valid goes up after the drawn gap and holds until
  // in_ready is seen at an edge; the tracker advances only then.
  task automatic send_char(input logic [BYTE_W-1:0] c);
    int gap;
    gap = source_gaps ? $urandom_range(0, MAX_WAIT) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= c;
    do @(posedge clk); while (!in_ready);
    decode_char(c);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(BYTE_W'(s[i]));
  endtask

  task automatic send_word(input logic [ID_W-1:0] w);
    for (int k = 3; k >= 0; k--) send_char(w[k*8 +: 8]);
  endtask

  // Sender goes quiet until the last result is in, then lets the
  // output pipe settle before the next phase.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Receiver: random stall after each transfer, plus a long hold on request
  always @(posedge clk) begin
    if (hold_asked != hold_given) begin
      hold_given = hold_asked;
      hold_left  = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) stall_left = sink_stalls ? $urandom_range(0, MAX_WAIT) : 0;
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Monitor: every output transfer against the oldest queued frame
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_frames.size() == 0) begin
        $error("unexpected result: command_code %0d frame_length %0d",
               command_code, frame_length);
        fail_count++;
      end else begin
        ucfd_result_t want;
        want = pending_frames.pop_front();
        frames_checked++;
        compare_field("command_code", 32'(want.command_code), 32'(command_code));
        compare_field("frame_length", 32'(want.frame_length), 32'(frame_length));
        compare_field("payload_first", 32'(want.payload_first), 32'(payload_first));
        compare_field("payload_second", 32'(want.payload_second), 32'(payload_second));
        compare_field("payload_third", 32'(want.payload_third), 32'(payload_third));
        compare_field("is_query", 32'(want.is_query), 32'(is_query));
        compare_field("decimal_value", 32'(want.decimal_value), 32'(decimal_value));
        compare_field("digits_valid", 32'(want.digits_valid), 32'(digits_valid));
      end
    end
  end

  // Payload mix: digits dominate so decimal values show up often
  function automatic logic [BYTE_W-1:0] payload_char();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return CH_ZERO + BYTE_W'($urandom_range(0, 9));
    if (pick < 58) return CH_QUERY;
    if (pick < 62) return CH_END;
    if (pick < 64) return CH_START;
    if (pick < 67) return CH_ZERO - 8'd1;   // just below '0'
    if (pick < 70) return CH_NINE + 8'd1;   // just above '9'
    return BYTE_W'($urandom);
  endfunction

  // Frame of the usual shape: '#', payload, command word, '!'. A few lose
  // their start, their end, or part of the word.
  task automatic send_random_frame(input int max_payload);
    int               plen;
    int               pick;
    int               nbytes;
    int               flip;
    logic [ID_W-1:0]  word;
    logic [BYTE_W-1:0] c;
    if ($urandom_range(0, 9) != 0) send_char(CH_START);
    plen = ($urandom_range(0, 3) == 0) ? 2 : $urandom_range(0, max_payload);
    for (int k = 0; k < plen; k++) begin
      c = payload_char();
      if (k == 0 && $urandom_range(0, 3) == 0) c = CH_QUERY;
      send_char(c);
    end
    pick = $urandom_range(0, 99);
    word = CMD_WORDS[$urandom_range(0, NUM_CMDS - 1)];
    if (pick >= 80) begin
      word = $urandom;
    end else if (pick >= 60) begin
      // near miss: one bit off a real command word
      flip = $urandom_range(0, ID_W - 1);
      word[flip] = ~word[flip];
    end
    nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : 4;
    for (int k = 3; k >= 4 - nbytes; k--) send_char(word[k*8 +: 8]);
    if ($urandom_range(0, 9) != 0) send_char(CH_END);
  endtask

  // Directed corner frames. The lone '!' must come first so that it sees
  // the reset window and reset payload bytes.
  task automatic test_special_frames();
    send_text("!");          // short frame, all reset zeros
    send_text("#!");         // terminator lands on payload position 1
    send_text("#5!");        // terminator on position 2
    send_text("#99!");       // terminator on position 3, top decimal value
    send_text("#/:!");       // neighbors of the digit range
    send_text("#?0Cap?!");   // query: '?' first and length 8
    send_text("Play!");      // command word carried past the frame start
  endtask

  // Every command word once in a clean frame, with a digit pair in front
  task automatic test_command_words();
    for (int k = 0; k < NUM_CMDS; k++) begin
      send_char(CH_START);
      send_char(CH_ZERO + BYTE_W'($urandom_range(0, 9)));
      send_char(CH_ZERO + BYTE_W'($urandom_range(0, 9)));
      send_word(CMD_WORDS[k]);
      send_char(CH_END);
    end
    send_text("#00Tim!");    // short word, never matches
  endtask

  // Receiver holds off while the sender streams back to back, so both
  // output entries fill and in_ready has to drop.
  task automatic test_output_backpressure();
    source_gaps = 1'b0;
    hold_asked <= hold_asked + 1;
    for (int k = 0; k < 4; k++) begin
      send_char(CH_START);
      send_char(CH_ZERO + BYTE_W'(k));
      send_char(CH_NINE - BYTE_W'(k));
      send_word(CMD_WORDS[$urandom_range(0, NUM_CMDS - 1)]);
      send_char(CH_END);
    end
    repeat (8) send_char(CH_END);
    wait_for_results();
    source_gaps = 1'b1;
  endtask

  // Frames past the depth: position wraps, payload slots get rewritten,
  // and one frame ends exactly on the wrap so its length reads 0.
  task automatic test_long_frames();
    int plen;
    for (int n = 0; n < 4; n++) begin
      plen = (n == 0) ? DEPTH - 2 : $urandom_range(DEPTH, 2 * DEPTH + 10);
      send_char(CH_START);
      for (int k = 0; k < plen; k++) send_char(payload_char() & 8'h7E | 8'h40);
      send_char(CH_END);
    end
  endtask

  // Bulk of the run: mostly well-formed frames, some raw noise. Idling on
  // either side is switched off in stretches.
  task automatic test_random_traffic();
    int stop_at;
    stop_at = chars_sent + RANDOM_CHARS;
    while (chars_sent < stop_at) begin
      source_gaps = ($urandom_range(0, 3) != 0);
      sink_stalls <= ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 6)) send_char(BYTE_W'($urandom));
      else
        send_random_frame(9);
    end
    source_gaps = 1'b1;
    sink_stalls <= 1'b1;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_special_frames();
    wait_for_results();
    test_command_words();
    wait_for_results();
    test_output_backpressure();
    test_long_frames();
    wait_for_results();
    test_random_traffic();
    wait_for_results();
    $display("Run: %0d characters in, %0d frame results checked, %0d input stall cycles.",
             chars_sent, frames_checked, input_stalls);
    $display("Covered all command words, near misses, query and digit frames, wraps.");
    if (fail_count == 0) begin
      $display("PASS uart_command_frame_decoder_unit");
    end else begin
      $display("FAIL uart_command_frame_decoder_unit");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/ucfd_pkg.sv
src/ucfd_frame_track.sv
src/ucfd_cmd_match.sv
src/ucfd_out_buffer.sv
src/uart_command_frame_decoder_unit.sv
tb/sv/tb.sv
